>>> design/psu_pkg.sv
package psu_pkg;

  localparam int PARTICLES_DEF = 64;
  localparam int IDX_W = 6;
  localparam int POS_W = 32;
  localparam int SCORE_W = 63;
  localparam int WGT_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_INERTIA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COGNITIVE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOCIAL = 2'd2;

  localparam logic signed [WGT_W-1:0] INERTIA_RST = 16'sd2867;
  localparam logic signed [WGT_W-1:0] COGNITIVE_RST = 16'sd6144;
  localparam logic signed [WGT_W-1:0] SOCIAL_RST = 16'sd6144;

  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
  localparam logic [63:0] PROD_CAP = 64'h4000_0000_0000_0000;
  localparam logic [63:0] TERM_CAP = 64'h0000_0100_0000_0000;
  localparam logic signed [63:0] BEALE_C1 = 64'sd98304;
  localparam logic signed [63:0] BEALE_C2 = 64'sd147456;
  localparam logic signed [63:0] BEALE_C3 = 64'sd172032;
  localparam logic signed [63:0] VEL_LIM_Q28 = 64'sd5368709120;
  localparam logic signed [31:0] VEL_LIM_Q16 = 32'sd1310720;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_VEL,
    ST_MOVE,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_T1,
    ST_T2,
    ST_T3,
    ST_COMMIT,
    ST_OUT
  } psu_state_t;

  typedef struct packed {
    logic capture;
    logic read;
    logic vel;
    logic move;
    logic p1;
    logic p2;
    logic p3;
    logic t1;
    logic t2;
    logic t3;
    logic commit;
  } psu_cmd_t;

  typedef struct packed {
    logic is_update;
    logic mul_last;
  } psu_status_t;

endpackage

>>> design/particle_swarm_update_core.sv
// channel | direction | contents
// s_axis  | in        | tdata: particle_index, init_pos_x/y, init_vel_x/y; tuser: req_type
// m_axis  | out       | tdata: new_pos_x/y, new_score, global_x/y, global_score
// cfg     | in        | cfg_we, cfg_idx, cfg_data (weights)
// an item runs from one accept to the next through table read, velocity and move (update
// only), three beale products and three squared terms on one shared 32x32 multiplier,
// commit, output load. the result word sits in an output register, so the next word is
// taken while it waits; a result still unread at output load stalls.
// rst is synchronous; the particle table has no reset and needs a load before update.
module particle_swarm_update_core #(
  parameter int PARTICLES = psu_pkg::PARTICLES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [psu_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [psu_pkg::WGT_W-1:0] cfg_data,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // particle_index[5:0], init_pos_x, init_pos_y, init_vel_x, init_vel_y, pad to 136
  input  logic [135:0] s_axis_tdata,
  // req_type
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // new_pos_x, new_pos_y, new_score, global_x, global_y, global_score, pad to 256
  output logic [255:0] m_axis_tdata
);
  import psu_pkg::*;

  psu_cmd_t cmd;
  psu_status_t status;
  logic in_ready, out_load, out_take;
  logic signed [31:0] npx, npy, gx, gy;
  logic [SCORE_W-1:0] ns, gs;

  assign s_axis_tready = in_ready;
  assign out_take = m_axis_tvalid && m_axis_tready;

  psu_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_fire(s_axis_tvalid && in_ready),
    .out_busy(m_axis_tvalid), .out_take(out_take),
    .status(status), .cmd(cmd), .in_ready(in_ready), .out_load(out_load)
  );

  psu_datapath #(.PARTICLES(PARTICLES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .req_type(s_axis_tuser),
    .particle_index(s_axis_tdata[5:0]),
    .init_pos_x(s_axis_tdata[37:6]),
    .init_pos_y(s_axis_tdata[69:38]),
    .init_vel_x(s_axis_tdata[101:70]),
    .init_vel_y(s_axis_tdata[133:102]),
    .new_pos_x(npx), .new_pos_y(npy), .new_score(ns),
    .global_x(gx), .global_y(gy), .global_score(gs)
  );

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (out_load) m_axis_tvalid <= 1'b1;
    else if (out_take) m_axis_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) m_axis_tdata <= {2'b00, gs, gy, gx, ns, npy, npx};
  end

endmodule

>>> design/psu_ctrl.sv
module psu_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic out_busy,
  input  logic out_take,
  input  psu_pkg::psu_status_t status,
  output psu_pkg::psu_cmd_t cmd,
  output logic in_ready,
  output logic out_load
);
  import psu_pkg::*;

  psu_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // each product and squared term stays until the multiplier reports its last step
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_fire) state_next = ST_READ;
      ST_READ: state_next = status.is_update ? ST_VEL : ST_P1;
      ST_VEL: state_next = ST_MOVE;
      ST_MOVE: state_next = ST_P1;
      ST_P1: if (status.mul_last) state_next = ST_P2;
      ST_P2: if (status.mul_last) state_next = ST_P3;
      ST_P3: if (status.mul_last) state_next = ST_T1;
      ST_T1: if (status.mul_last) state_next = ST_T2;
      ST_T2: if (status.mul_last) state_next = ST_T3;
      ST_T3: if (status.mul_last) state_next = ST_COMMIT;
      ST_COMMIT: state_next = ST_OUT;
      ST_OUT: if (!out_busy || out_take) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.capture = 1'b1;
      end
      ST_READ: cmd.read = 1'b1;
      ST_VEL: cmd.vel = 1'b1;
      ST_MOVE: cmd.move = 1'b1;
      ST_P1: cmd.p1 = 1'b1;
      ST_P2: cmd.p2 = 1'b1;
      ST_P3: cmd.p3 = 1'b1;
      ST_T1: cmd.t1 = 1'b1;
      ST_T2: cmd.t2 = 1'b1;
      ST_T3: cmd.t3 = 1'b1;
      ST_COMMIT: cmd.commit = 1'b1;
      ST_OUT: out_load = !out_busy || out_take;
      default: ;
    endcase
  end

endmodule

>>> design/psu_datapath.sv
module psu_datapath #(
  parameter int PARTICLES = psu_pkg::PARTICLES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  psu_pkg::psu_cmd_t cmd,
  output psu_pkg::psu_status_t status,
  input  logic cfg_we,
  input  logic [psu_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [psu_pkg::WGT_W-1:0] cfg_data,
  input  logic req_type,
  input  logic [psu_pkg::IDX_W-1:0] particle_index,
  input  logic signed [31:0] init_pos_x,
  input  logic signed [31:0] init_pos_y,
  input  logic signed [31:0] init_vel_x,
  input  logic signed [31:0] init_vel_y,
  output logic signed [31:0] new_pos_x,
  output logic signed [31:0] new_pos_y,
  output logic [psu_pkg::SCORE_W-1:0] new_score,
  output logic signed [31:0] global_x,
  output logic signed [31:0] global_y,
  output logic [psu_pkg::SCORE_W-1:0] global_score
);
  import psu_pkg::*;

  localparam int AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;

  // multiplier steps: operand load, four partial products, cap and store
  localparam logic [2:0] MS_LOAD = 3'd0;
  localparam logic [2:0] MS_LL = 3'd1;
  localparam logic [2:0] MS_HL = 3'd2;
  localparam logic [2:0] MS_LH = 3'd3;
  localparam logic [2:0] MS_HH = 3'd4;
  localparam logic [2:0] MS_DONE = 3'd5;

  logic signed [WGT_W-1:0] w_in, w_cog, w_soc;
  logic [63:0] mem_pos [PARTICLES];
  logic [63:0] mem_vel [PARTICLES];
  logic [63:0] mem_best [PARTICLES];
  logic [SCORE_W-1:0] mem_bscore [PARTICLES];
  logic [63:0] rd_pos, rd_vel, rd_best;
  logic [SCORE_W-1:0] rd_bscore;

  logic kind, in_range;
  logic [AW-1:0] addr;
  logic signed [31:0] ivx, ivy;
  logic signed [31:0] px, py, vx, vy;
  logic signed [63:0] p1, p2, p3;
  logic [SCORE_W-1:0] score;
  logic signed [31:0] gx, gy;
  logic [SCORE_W-1:0] gscore;

  logic mul_on, mul_term;
  logic [2:0] mstep;
  logic [63:0] sel_a, sel_b, opa, opb;
  logic sel_neg, oneg;
  logic [31:0] half_a, half_b;
  logic [63:0] pp;
  logic [127:0] acc, acc_q;
  logic [63:0] mul_cap, mul_mag;
  logic signed [63:0] mul_signed;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_in <= INERTIA_RST;
      w_cog <= COGNITIVE_RST;
      w_soc <= SOCIAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_INERTIA: w_in <= cfg_data;
        CFG_COGNITIVE: w_cog <= cfg_data;
        CFG_SOCIAL: w_soc <= cfg_data;
        default: ;
      endcase
    end
  end

  assign status.is_update = kind;
  assign status.mul_last = (mstep == MS_DONE);

  function automatic logic [63:0] uabs(input logic signed [63:0] a);
    uabs = a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic [63:0] term_mag(input logic signed [63:0] c,
                                           input logic signed [63:0] t_x,
                                           input logic signed [63:0] p);
    logic [63:0] m;
    begin
      m = uabs(c - t_x + p);
      term_mag = (m > TERM_CAP) ? TERM_CAP : m;
    end
  endfunction

  function automatic logic [SCORE_W-1:0] add_sat(input logic [SCORE_W-1:0] a,
                                                input logic [SCORE_W-1:0] b);
    logic [SCORE_W:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      add_sat = s[SCORE_W] ? SCORE_MAX : s[SCORE_W-1:0];
    end
  endfunction

  function automatic logic signed [31:0] new_vel(
      input logic signed [WGT_W-1:0] wi, input logic signed [WGT_W-1:0] wc,
      input logic signed [WGT_W-1:0] ws, input logic signed [31:0] v,
      input logic signed [31:0] pos, input logic signed [31:0] own,
      input logic signed [31:0] glob);
    logic signed [63:0] sum, sh;
    begin
      sum = 64'(wi * 64'(v)) + 64'(wc * (64'(own) - 64'(pos)))
          + 64'(ws * (64'(glob) - 64'(pos)));
      sh = (sum + VEL_LIM_Q28) >>> 12;
      if (sum <= -VEL_LIM_Q28) new_vel = -VEL_LIM_Q16;
      else if (sum >= VEL_LIM_Q28) new_vel = VEL_LIM_Q16;
      else new_vel = 32'(sh) - VEL_LIM_Q16;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v > 33'sd2147483647) sat32 = 32'h7fff_ffff;
    else if (v < -33'sd2147483648) sat32 = 32'h8000_0000;
    else sat32 = v[31:0];
  endfunction

  // table reads, registered
  always_ff @(posedge clk) begin
    rd_pos <= mem_pos[addr];
    rd_vel <= mem_vel[addr];
    rd_best <= mem_best[addr];
    rd_bscore <= mem_bscore[addr];
  end

  // shared multiplier, magnitudes in, floor(a*b/2^16) capped out
  assign mul_on = cmd.p1 | cmd.p2 | cmd.p3 | cmd.t1 | cmd.t2 | cmd.t3;
  assign mul_term = cmd.t1 | cmd.t2 | cmd.t3;

  always_comb begin
    sel_a = uabs(64'(px));
    sel_b = uabs(64'(py));
    sel_neg = px[31] ^ py[31];
    unique case (1'b1)
      cmd.p2: begin
        sel_a = uabs(p1);
        sel_neg = p1[63] ^ py[31];
      end
      cmd.p3: begin
        sel_a = uabs(p2);
        sel_neg = p2[63] ^ py[31];
      end
      cmd.t1: begin
        sel_a = term_mag(BEALE_C1, 64'(px), p1);
        sel_b = sel_a;
      end
      cmd.t2: begin
        sel_a = term_mag(BEALE_C2, 64'(px), p2);
        sel_b = sel_a;
      end
      cmd.t3: begin
        sel_a = term_mag(BEALE_C3, 64'(px), p3);
        sel_b = sel_a;
      end
      default: ;
    endcase
  end

  always_comb begin
    half_a = opa[31:0];
    half_b = opb[31:0];
    unique case (mstep)
      MS_HL: half_a = opa[63:32];
      MS_LH: half_b = opb[63:32];
      MS_HH: begin
        half_a = opa[63:32];
        half_b = opb[63:32];
      end
      default: ;
    endcase
  end

  assign pp = 64'(half_a) * 64'(half_b);
  assign acc_q = acc >> 16;
  assign mul_cap = mul_term ? {1'b0, SCORE_MAX} : PROD_CAP;
  assign mul_mag = (acc_q > 128'(mul_cap)) ? mul_cap : acc_q[63:0];
  assign mul_signed = oneg ? -$signed(mul_mag) : $signed(mul_mag);

  always_ff @(posedge clk) begin
    if (rst) mstep <= MS_LOAD;
    else if (mul_on && mstep != MS_DONE) mstep <= mstep + 3'd1;
    else mstep <= MS_LOAD;
  end

  always_ff @(posedge clk) begin
    if (mul_on) begin
      unique case (mstep)
        MS_LOAD: begin
          opa <= sel_a;
          opb <= sel_b;
          oneg <= sel_neg;
        end
        MS_LL: acc <= 128'(pp);
        MS_HL, MS_LH: acc <= acc + (128'(pp) << 32);
        MS_HH: acc <= acc + (128'(pp) << 64);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind <= req_type;
      in_range <= (32'(particle_index) < PARTICLES);
      addr <= AW'(particle_index);
      px <= init_pos_x;
      py <= init_pos_y;
      ivx <= init_vel_x;
      ivy <= init_vel_y;
    end
    if (cmd.vel) begin
      vx <= new_vel(w_in, w_cog, w_soc, rd_vel[31:0], rd_pos[31:0], rd_best[31:0], gx);
      vy <= new_vel(w_in, w_cog, w_soc, rd_vel[63:32], rd_pos[63:32], rd_best[63:32], gy);
    end
    if (cmd.move) begin
      px <= sat32(33'($signed(rd_pos[31:0])) + 33'(vx));
      py <= sat32(33'($signed(rd_pos[63:32])) + 33'(vy));
    end
    if (mstep == MS_DONE) begin
      if (cmd.p1) p1 <= mul_signed;
      if (cmd.p2) p2 <= mul_signed;
      if (cmd.p3) p3 <= mul_signed;
      if (cmd.t1) score <= mul_mag[SCORE_W-1:0];
      if (cmd.t2) score <= add_sat(score, mul_mag[SCORE_W-1:0]);
      if (cmd.t3) score <= add_sat(score, mul_mag[SCORE_W-1:0]);
    end
  end

  // the load velocity comes from ivx/ivy; vx/vy are stored on update only
  always_ff @(posedge clk) begin
    if (cmd.commit && in_range) begin
      mem_pos[addr] <= {px, py} == 64'd0 ? 64'd0 : {py, px};
      mem_vel[addr] <= kind ? {vy, vx} : {ivy, ivx};
      if (!kind || score < rd_bscore) begin
        mem_best[addr] <= {py, px};
        mem_bscore[addr] <= score;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gx <= '0;
      gy <= '0;
      gscore <= SCORE_MAX;
    end else if (cmd.commit && in_range &&
                 ((!kind && addr == '0) || score < gscore)) begin
      gx <= px;
      gy <= py;
      gscore <= score;
    end
  end

  assign new_pos_x = in_range ? px : '0;
  assign new_pos_y = in_range ? py : '0;
  assign new_score = in_range ? score : '0;
  assign global_x = gx;
  assign global_y = gy;
  assign global_score = gscore;

endmodule

>>> bench/tb_particle_swarm_update_core.sv
`timescale 1ns / 100ps

module tb_particle_swarm_update_core;
  import psu_pkg::*;

  localparam int NPART = 64;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic        is_update;
    logic [5:0]  idx;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] vx;
    logic [31:0] vy;
  } swarm_req_t;

  typedef struct packed {
    logic [31:0]        pos_x;
    logic [31:0]        pos_y;
    logic [SCORE_W-1:0] score;
    logic [31:0]        best_x;
    logic [31:0]        best_y;
    logic [SCORE_W-1:0] best_score;
  } swarm_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [WGT_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [255:0] m_axis_tdata;

  particle_swarm_update_core DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  longint w_inertia, w_cognitive, w_social;
  int pos_x_tab[NPART], pos_y_tab[NPART], vel_x_tab[NPART], vel_y_tab[NPART];
  int own_x_tab[NPART], own_y_tab[NPART];
  longint unsigned own_score_tab[NPART];
  int swarm_x, swarm_y;
  longint unsigned swarm_score;
  bit loaded[NPART];

  swarm_req_t pending_reqs[$];
  swarm_res_t expected_results[$];
  int errors = 0, mismatches = 0, words_sent = 0, words_seen = 0, words_offered = 0;
  bit hold_off = 1'b0;
  bit done_driving = 1'b0;
  longint cycles = 0;

  function automatic longint unsigned mag(longint a);
    return a < 0 ? longint'(0) - a : a;
  endfunction

  // floor(a*b/2^16) capped
  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b,
                                           longint unsigned cap);
    logic [127:0] p;
    p = (128'(a) * 128'(b)) >> 16;
    return (p > 128'(cap)) ? cap : p[63:0];
  endfunction

  function automatic longint qmul_s(longint a, longint b);
    longint unsigned m;
    m = qmul(mag(a), mag(b), 64'h4000_0000_0000_0000);
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned term_square(longint c, longint x, longint p);
    longint unsigned m;
    m = mag(c - x + p);
    if (m > 64'h100_0000_0000) m = 64'h100_0000_0000;
    return qmul(m, m, 64'h7FFF_FFFF_FFFF_FFFF);
  endfunction

  function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : s;
  endfunction

  function automatic longint unsigned beale_score(int xi, int yi);
    longint x, y, p1, p2, p3;
    longint unsigned s;
    x = xi; y = yi;
    p1 = qmul_s(x, y);
    p2 = qmul_s(p1, y);
    p3 = qmul_s(p2, y);
    s = term_square(98304, x, p1);
    s = sat_add(s, term_square(147456, x, p2));
    return sat_add(s, term_square(172032, x, p3));
  endfunction

  function automatic int step_velocity(longint v, longint p, longint own, longint glob);
    longint lim, sum;
    lim = 64'sd5368709120;
    sum = w_inertia * v + w_cognitive * (own - p) + w_social * (glob - p);
    if (sum <= -lim) return -1310720;
    if (sum >= lim) return 1310720;
    return int'(((sum + lim) >>> 12) - 1310720);
  endfunction

  function automatic int clip32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return int'(v);
  endfunction

  function automatic void swarm_reset();
    w_inertia = 2867; w_cognitive = 6144; w_social = 6144;
    swarm_x = 0; swarm_y = 0; swarm_score = 64'h7FFF_FFFF_FFFF_FFFF;
  endfunction

  function automatic swarm_res_t swarm_step(swarm_req_t r);
    swarm_res_t o;
    int i, vx, vy, px, py;
    longint unsigned sc;
    i = r.idx;
    px = 0; py = 0; sc = 0;
    if (!r.is_update) begin
      px = r.px; py = r.py;
      sc = beale_score(px, py);
      pos_x_tab[i] = px; pos_y_tab[i] = py;
      vel_x_tab[i] = r.vx; vel_y_tab[i] = r.vy;
      own_x_tab[i] = px; own_y_tab[i] = py; own_score_tab[i] = sc;
      if (i == 0 || sc < swarm_score) begin
        swarm_x = px; swarm_y = py; swarm_score = sc;
      end
    end else begin
      vx = step_velocity(vel_x_tab[i], pos_x_tab[i], own_x_tab[i], swarm_x);
      vy = step_velocity(vel_y_tab[i], pos_y_tab[i], own_y_tab[i], swarm_y);
      vel_x_tab[i] = vx; vel_y_tab[i] = vy;
      px = clip32(longint'(pos_x_tab[i]) + vx);
      py = clip32(longint'(pos_y_tab[i]) + vy);
      pos_x_tab[i] = px; pos_y_tab[i] = py;
      sc = beale_score(px, py);
      if (sc < own_score_tab[i]) begin
        own_x_tab[i] = px; own_y_tab[i] = py; own_score_tab[i] = sc;
      end
      if (sc < swarm_score) begin
        swarm_x = px; swarm_y = py; swarm_score = sc;
      end
    end
    o.pos_x = px; o.pos_y = py; o.score = sc[62:0];
    o.best_x = swarm_x; o.best_y = swarm_y; o.best_score = swarm_score[62:0];
    return o;
  endfunction

  // driver: bursts and gaps, tvalid held until the word is accepted
  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && words_sent != words_offered) begin
        // keep offering the same word
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        swarm_req_t r;
        r = pending_reqs.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= r.is_update;
        s_axis_tdata <= {2'd0, r.vy, r.vx, r.py, r.px, r.idx};
        words_offered <= words_offered + 1;
        expected_results.push_back(swarm_step(r));
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk)
    if (s_axis_tvalid && s_axis_tready) words_sent <= words_sent + 1;

  // receiver stall pattern
  int stall_mode = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: m_axis_tready <= !hold_off;
        1: m_axis_tready <= !hold_off && ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= !hold_off && ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    swarm_res_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.pos_x = m_axis_tdata[31:0];
      got.pos_y = m_axis_tdata[63:32];
      got.score = m_axis_tdata[126:64];
      got.best_x = m_axis_tdata[158:127];
      got.best_y = m_axis_tdata[190:159];
      got.best_score = m_axis_tdata[253:191];
      words_seen <= words_seen + 1;
      if (expected_results.size() == 0) begin
        errors <= errors + 1;
        $display("unexpected result word at cycle %0d", cycles);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          errors <= errors + 1;
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: pos %h %h score %h best %h %h %h / expected %h %h %h %h %h %h",
                     got.pos_x, got.pos_y, got.score, got.best_x, got.best_y, got.best_score,
                     want.pos_x, want.pos_y, want.score, want.best_x, want.best_y,
                     want.best_score);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $signed($urandom_range(0, 2 * 262144)) - 262144;
      default: return $signed($urandom_range(0, 2 * 65536 * 5)) - 65536 * 5;
    endcase
  endfunction

  function automatic void queue_load(int i, int px, int py, int vx, int vy);
    swarm_req_t r;
    r.is_update = 1'b0; r.idx = i; r.px = px; r.py = py; r.vx = vx; r.vy = vy;
    pending_reqs.push_back(r);
    loaded[i] = 1'b1;
  endfunction

  // update words still carry random payload bits, which the block ignores
  function automatic void queue_update(int i);
    swarm_req_t r;
    r.is_update = 1'b1; r.idx = i;
    r.px = $urandom(); r.py = $urandom(); r.vx = $urandom(); r.vy = $urandom();
    pending_reqs.push_back(r);
  endfunction

  function automatic void queue_random(int n);
    int i;
    repeat (n) begin
      i = $urandom_range(0, NPART - 1);
      if (!loaded[i] || $urandom_range(0, 4) == 0)
        queue_load(i, rand_coord(), rand_coord(), $urandom_range(0, 3) == 0 ? $urandom() :
                   $signed($urandom_range(0, 131072)) - 65536, $urandom());
      else
        queue_update(i);
    end
  endfunction

  task automatic drain();
    wait (pending_reqs.size() == 0 && !s_axis_tvalid && expected_results.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_weight(logic [CFG_IDX_W-1:0] which, logic [WGT_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_idx <= which; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (which)
      CFG_INERTIA: w_inertia = $signed(val);
      CFG_COGNITIVE: w_cognitive = $signed(val);
      default: w_social = $signed(val);
    endcase
  endtask

  initial begin
    int k;
    swarm_reset();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, index zero override, velocity extremes, updates
    queue_load(5, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_load(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_load(63, 3 * 65536, 32768, 0, 0);
    queue_load(1, 3 * 65536, 32768, 65536, -65536);
    queue_load(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    queue_load(2, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_load(3, 32'h7FFF_0000, 32'h7FFF_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_update(2); queue_update(3); queue_update(3); queue_update(5);
    queue_update(0); queue_update(63); queue_update(1); queue_update(5);
    drain();

    write_weight(CFG_INERTIA, 16'h7FFF);
    write_weight(CFG_COGNITIVE, 16'h8000);
    write_weight(CFG_SOCIAL, 16'h7FFF);
    queue_random(200);
    drain();

    write_weight(CFG_INERTIA, 16'h8000);
    write_weight(CFG_COGNITIVE, 16'h7FFF);
    write_weight(CFG_SOCIAL, 16'h8000);
    queue_random(200);
    drain();

    write_weight(CFG_INERTIA, INERTIA_RST);
    write_weight(CFG_COGNITIVE, COGNITIVE_RST);
    write_weight(CFG_SOCIAL, SOCIAL_RST);
    // long receiver hold-off while the sender keeps going
    queue_random(300);
    hold_off = 1'b1;
    repeat (600) @(posedge clk);
    hold_off = 1'b0;
    drain();

    for (k = 0; k < 3; k++) begin
      write_weight(CFG_INERTIA, 16'($urandom()));
      write_weight(CFG_COGNITIVE, 16'($urandom_range(0, 8191)));
      write_weight(CFG_SOCIAL, 16'($urandom_range(0, 8191)));
      queue_random(300);
      drain();
    end

    $display("%0d words sent, %0d result words checked over several weight settings",
             words_sent, words_seen);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> files.f
design/psu_pkg.sv
design/psu_ctrl.sv
design/psu_datapath.sv
design/particle_swarm_update_core.sv
bench/tb_particle_swarm_update_core.sv
